FILE: sv/mtt_pkg.sv
// mtt_pkg: shared types and constants of the mass/time tolerance match core.
// Field widths, register indexes, sequencer states and the scan beat struct.
// No dependencies.
package mtt_pkg;

    localparam int MASS_W   = 28;
    localparam int TIME_W   = 20;
    localparam int FIDX_W   = 6;
    localparam int ABS_W    = 24;
    localparam int PPM_W    = 10;
    localparam int CNT_W    = 7;
    localparam int CFG_W    = 24;
    localparam int CFGIDX_W = 2;
    localparam int PROD_W   = MASS_W + PPM_W;   // ion mass times ppm
    localparam int SCALE_W  = 20;
    localparam int SCALED_W = MASS_W + SCALE_W; // mass difference times 1e6

    localparam logic [SCALE_W-1:0] PPM_SCALE = 20'd1000000;

    localparam logic [TIME_W-1:0] TIME_TOL_RST = 20'd1000;
    localparam logic [ABS_W-1:0]  ABS_TOL_RST  = 24'd1000;
    localparam logic [PPM_W-1:0]  PPM_TOL_RST  = 10'd10;
    localparam logic [CNT_W-1:0]  COUNT_RST    = 7'd0;

    typedef enum logic [CFGIDX_W-1:0] {
        REG_TIME_TOL  = 2'd0,
        REG_ABS_TOL   = 2'd1,
        REG_PPM_TOL   = 2'd2,
        REG_FEAT_CNT  = 2'd3
    } mtt_reg_t;

    typedef enum logic {
        MODE_LOAD  = 1'b0,
        MODE_QUERY = 1'b1
    } mtt_mode_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PREP,
        ST_SCAN,
        ST_DRAIN,
        ST_FINISH
    } mtt_state_t;

    // One table entry moving through the compare pipeline.
    typedef struct packed {
        logic              vld;
        logic [FIDX_W-1:0] idx;
        logic [MASS_W-1:0] mass;
        logic [TIME_W-1:0] tm;
    } mtt_entry_t;

endpackage

FILE: sv/mtt_match_unit.sv
// mtt_match_unit: three-stage compare unit shared by every entry of a scan.
// Takes one table entry per cycle and flags it when both tolerances pass.
// Depends on mtt_pkg.
module mtt_match_unit (
    input  logic                         clk,
    input  logic                         rst_n,
    input  mtt_pkg::mtt_entry_t          entry_in,
    input  logic [mtt_pkg::MASS_W-1:0]   q_mass,
    input  logic [mtt_pkg::TIME_W-1:0]   q_time,
    input  logic [mtt_pkg::PROD_W-1:0]   ppm_prod,
    input  logic [mtt_pkg::TIME_W-1:0]   time_tol,
    input  logic [mtt_pkg::ABS_W-1:0]    abs_tol,
    output mtt_pkg::mtt_entry_t          hit_out,
    output logic                         busy
);
    import mtt_pkg::*;

    mtt_entry_t          s1_reg, s2_reg, s3_reg;
    logic [MASS_W-1:0]   dm_reg;
    logic [TIME_W-1:0]   dt_reg;
    logic [SCALED_W-1:0] scaled_reg;
    logic                abs_ok_reg;
    logic                time_ok_reg;
    logic [MASS_W-1:0]   dm_next;
    logic [TIME_W-1:0]   dt_next;
    logic                hit_next;

    always_comb
    begin
        dm_next = (entry_in.mass >= q_mass) ? (entry_in.mass - q_mass)
                                            : (q_mass - entry_in.mass);
        dt_next = (entry_in.tm >= q_time) ? (entry_in.tm - q_time)
                                          : (q_time - entry_in.tm);
        hit_next = s2_reg.vld && time_ok_reg &&
                   (abs_ok_reg || (scaled_reg <= SCALED_W'(ppm_prod)));
    end

    // stage 1: absolute differences, stage 2: scale and side compares,
    // stage 3: final decision
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_reg <= '0;
            s2_reg <= '0;
            s3_reg <= '0;
        end
        else
        begin
            s1_reg <= entry_in;
            s2_reg <= s1_reg;
            s3_reg <= {hit_next, s2_reg.idx, s2_reg.mass, s2_reg.tm};
        end
    end

    always_ff @(posedge clk)
    begin
        dm_reg      <= dm_next;
        dt_reg      <= dt_next;
        scaled_reg  <= SCALED_W'(dm_reg) * SCALED_W'(PPM_SCALE);
        abs_ok_reg  <= dm_reg <= MASS_W'(abs_tol);
        time_ok_reg <= dt_reg <= time_tol;
    end

    assign hit_out = s3_reg;
    assign busy    = s1_reg.vld | s2_reg.vld;

endmodule

FILE: sv/mass_time_tolerance_match_core.sv
// mass_time_tolerance_match_core: feature table with tolerance matching queries.
// Holds the table memory, configuration registers, scan sequencer and result register.
// Depends on mtt_pkg and mtt_match_unit.
//
//  channel   | handshake                  | payload
//  ----------+----------------------------+------------------------------------------
//  input     | start & !busy              | mode, entry_index, mass_value, time_value
//  result    | result_valid (one cycle)   | match_found, feature_index, feature_mass,
//            |                            | feature_time, last
//  config    | cfg_we                     | cfg_index, cfg_data
//
// A load beat writes its table slot at the accepting edge; busy stays low.
// A query beat keeps busy high while the sequencer forms ion mass times ppm
// and the scan length, feature_count capped at the table depth, then steps
// the single memory read port and the shared compare unit through the table
// entry by entry and drains the pipeline; then the final result goes out.
// Results come out one per cycle at most and cannot be stalled.
// Reset restores the register defaults and idles the sequencer; the table
// contents are left as they are.
module mass_time_tolerance_match_core #(
    parameter int TABLE_DEPTH = 64
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    output logic                           busy,
    input  logic                           mode,
    input  logic [mtt_pkg::FIDX_W-1:0]     entry_index,
    input  logic [mtt_pkg::MASS_W-1:0]     mass_value,
    input  logic [mtt_pkg::TIME_W-1:0]     time_value,
    input  logic                           cfg_we,
    input  logic [mtt_pkg::CFGIDX_W-1:0]   cfg_index,
    input  logic [mtt_pkg::CFG_W-1:0]      cfg_data,
    output logic                           result_valid,
    output logic                           match_found,
    output logic [mtt_pkg::FIDX_W-1:0]     feature_index,
    output logic [mtt_pkg::MASS_W-1:0]     feature_mass,
    output logic [mtt_pkg::TIME_W-1:0]     feature_time,
    output logic                           last
);
    import mtt_pkg::*;

    localparam int ADDR_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(TABLE_DEPTH);

    // configuration registers
    logic [TIME_W-1:0] time_tol_reg;
    logic [ABS_W-1:0]  abs_tol_reg;
    logic [PPM_W-1:0]  ppm_tol_reg;
    logic [CNT_W-1:0]  feat_cnt_reg;

    // table memory
    logic [MASS_W+TIME_W-1:0] table_mem [TABLE_DEPTH];
    logic [MASS_W+TIME_W-1:0] rd_data_reg;
    logic                     rd_vld_reg;
    logic [FIDX_W-1:0]        rd_idx_reg;

    // sequencer
    mtt_state_t       state_reg, state_next;
    logic [CNT_W-1:0] scan_cnt_reg, scan_cnt_next;
    logic [CNT_W-1:0] scan_len_reg;
    logic             rd_en;
    logic             accept;
    logic             load_we;

    // query operands
    logic [MASS_W-1:0] q_mass_reg;
    logic [TIME_W-1:0] q_time_reg;
    logic [PROD_W-1:0] ppm_prod_reg;

    // held match waiting to learn whether it is the final one
    mtt_entry_t pend_reg;

    mtt_entry_t entry_beat;
    mtt_entry_t hit_beat;
    logic       unit_busy;

    assign busy    = (state_reg != ST_IDLE);
    assign accept  = start && !busy;
    assign load_we = accept && (mode == MODE_LOAD) &&
                     ({1'b0, entry_index} < DEPTH_CNT);

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            time_tol_reg <= TIME_TOL_RST;
            abs_tol_reg  <= ABS_TOL_RST;
            ppm_tol_reg  <= PPM_TOL_RST;
            feat_cnt_reg <= COUNT_RST;
        end
        else if (cfg_we)
        begin
            unique case (mtt_reg_t'(cfg_index))
                REG_TIME_TOL: time_tol_reg <= cfg_data[TIME_W-1:0];
                REG_ABS_TOL:  abs_tol_reg  <= cfg_data[ABS_W-1:0];
                REG_PPM_TOL:  ppm_tol_reg  <= cfg_data[PPM_W-1:0];
                REG_FEAT_CNT: feat_cnt_reg <= cfg_data[CNT_W-1:0];
                default:      ;
            endcase
        end
    end

    // table: one write port for loads, one registered read port for the scan
    always_ff @(posedge clk)
    begin
        if (load_we)
        begin
            table_mem[entry_index[ADDR_W-1:0]] <= {mass_value, time_value};
        end
        if (rd_en)
        begin
            rd_data_reg <= table_mem[scan_cnt_reg[ADDR_W-1:0]];
        end
        rd_idx_reg <= scan_cnt_reg[FIDX_W-1:0];
    end

    // latch the query and form the relative tolerance bound once per query
    always_ff @(posedge clk)
    begin
        if (accept && (mode == MODE_QUERY))
        begin
            q_mass_reg <= mass_value;
            q_time_reg <= time_value;
        end
        if (state_reg == ST_PREP)
        begin
            ppm_prod_reg <= PROD_W'(q_mass_reg) * PROD_W'(ppm_tol_reg);
            scan_len_reg <= (feat_cnt_reg > DEPTH_CNT) ? DEPTH_CNT : feat_cnt_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            scan_cnt_reg <= '0;
            rd_vld_reg   <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            scan_cnt_reg <= scan_cnt_next;
            rd_vld_reg   <= rd_en;
        end
    end

    always_comb
    begin
        state_next    = state_reg;
        scan_cnt_next = scan_cnt_reg;
        rd_en         = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept && (mode == MODE_QUERY))
                begin
                    state_next = ST_PREP;
                end
            end
            ST_PREP:
            begin
                scan_cnt_next = '0;
                state_next    = ST_SCAN;
            end
            ST_SCAN:
            begin
                // advance one entry per cycle until the scan length is reached
                if (scan_cnt_reg == scan_len_reg)
                begin
                    state_next = ST_DRAIN;
                end
                else
                begin
                    rd_en         = 1'b1;
                    scan_cnt_next = scan_cnt_reg + 1'b1;
                end
            end
            ST_DRAIN:
            begin
                if (!rd_vld_reg && !unit_busy)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        entry_beat.vld  = rd_vld_reg;
        entry_beat.idx  = rd_idx_reg;
        entry_beat.mass = rd_data_reg[MASS_W+TIME_W-1:TIME_W];
        entry_beat.tm   = rd_data_reg[TIME_W-1:0];
    end

    mtt_match_unit u_match (
        .clk      (clk),
        .rst_n    (rst_n),
        .entry_in (entry_beat),
        .q_mass   (q_mass_reg),
        .q_time   (q_time_reg),
        .ppm_prod (ppm_prod_reg),
        .time_tol (time_tol_reg),
        .abs_tol  (abs_tol_reg),
        .hit_out  (hit_beat),
        .busy     (unit_busy)
    );

    // Hold each match until the next one shows up, so the final match can be
    // tagged with last. A new match pushes the held one out as a beat.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg     <= '0;
            result_valid <= 1'b0;
        end
        else
        begin
            result_valid <= 1'b0;
            if (state_reg == ST_PREP)
            begin
                pend_reg.vld <= 1'b0;
            end
            else if (hit_beat.vld)
            begin
                pend_reg     <= hit_beat;
                result_valid <= pend_reg.vld;
            end
            else if (state_reg == ST_FINISH)
            begin
                result_valid <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (hit_beat.vld)
        begin
            match_found   <= 1'b1;
            feature_index <= pend_reg.idx;
            feature_mass  <= pend_reg.mass;
            feature_time  <= pend_reg.tm;
            last          <= 1'b0;
        end
        else if (state_reg == ST_FINISH)
        begin
            // emit the held match as final, or a no-match beat
            match_found   <= pend_reg.vld;
            feature_index <= pend_reg.vld ? pend_reg.idx : '0;
            feature_mass  <= pend_reg.vld ? pend_reg.mass : '0;
            feature_time  <= pend_reg.vld ? pend_reg.tm : '0;
            last          <= 1'b1;
        end
    end

endmodule
